>>> hw/rtl/tccw_pkg.sv
// tccw_pkg: shared types and constants of the text console cell writer.
// Holds the input and result word layouts, mode codes and character codes.
// No dependencies; every other file imports it.
package tccw_pkg;

  localparam int unsigned CELL_W  = 16;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned INDEX_W = 11;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR    = 8'h0F;

  typedef struct packed {
    mode_t              mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;
  } out_word_t;

endpackage

>>> hw/rtl/tccw_store.sv
// tccw_store: screen cell memory, one write port and one registered read port.
// Depends on tccw_pkg for the cell width.
module tccw_store import tccw_pkg::*; #(
  parameter  int unsigned DEPTH = 2000,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/text_console_cell_writer.sv
// text_console_cell_writer: text-mode console engine over a ROWS x COLUMNS cell store.
// Depends on tccw_pkg (word types, codes) and tccw_store (cell memory).
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+---------------------------------
//   in      | in        | in_valid / in_ready   | in_word_t: mode, char_code, index
//   out     | out       | out_valid / out_ready | out_word_t: cursor_pos, cell_value
//   cfg     | in        | cfg_valid / cfg_ready | 8-bit text_color attribute
//
// Steps: put, read and the unused mode are accepted, then the result is loaded.
// A clear blanks every cell, one blanked cell per cycle, then loads the result. A put that
// runs past the last row adds a scroll first: one copied cell per cycle through the
// read and write ports, a drain step for the last copy, then the blanked bottom row.
// Reset starts a blanking pass over every cell; in_ready stays low until
// it is done, while cfg writes are taken at any time. The result register lets
// the next word enter while the last result still waits on out_ready.
module text_console_cell_writer import tccw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CHAR_W-1:0] cfg_data
);

  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned AW         = $clog2(CELL_COUNT);
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned ROW_W      = $clog2(ROWS);

  localparam logic [AW-1:0]    LAST_CELL     = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]    COPY_COUNT    = AW'(CELL_COUNT - COLUMNS);
  localparam logic [AW-1:0]    COPY_LAST     = AW'(CELL_COUNT - COLUMNS - 1);
  localparam logic [AW-1:0]    LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0]    ROW_STRIDE    = AW'(COLUMNS);
  localparam logic [COL_W-1:0] COL_LAST      = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST      = ROW_W'(ROWS - 1);

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_COPY  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_BLANK = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     pos, pos_next;       // linear cursor, row*COLUMNS + col
  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [AW-1:0]     sweep, sweep_next;   // address counter of the pass sequencer
  logic              wr_pend, wr_pend_next;
  logic [AW-1:0]     wr_addr_d;           // copy target: the previous sweep address, registered
  logic              read_hit, read_hit_next;
  logic [CHAR_W-1:0] text_color;
  logic              line_feed;
  logic              in_range;
  logic              out_load;
  logic [CELL_W-1:0] blank_cell;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  tccw_store #(
    .DEPTH(CELL_COUNT)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign blank_cell = {text_color, CHAR_BLANK};
  assign in_range   = int'(in_data.cell_index) < CELL_COUNT;

  // attribute register: the cfg channel is always open
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (cfg_valid) begin
      text_color <= cfg_data;
    end
  end

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    row_next      = row;
    col_next      = col;
    sweep_next    = sweep;
    wr_pend_next  = 1'b0;
    read_hit_next = read_hit;
    line_feed     = 1'b0;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = pos;
    wr_data       = blank_cell;
    rd_en         = 1'b0;
    rd_addr       = sweep + ROW_STRIDE;

    case (state)
      // blank the whole store after reset with the reset attribute
      ST_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = sweep;
        wr_data    = {RESET_COLOR, CHAR_BLANK};
        sweep_next = sweep + 1'b1;
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end
      end

      // take a word, do any single-cell work right away, or start a clear or scroll pass
      ST_IDLE: begin
        if (in_valid) begin
          read_hit_next = 1'b0;
          state_next    = ST_EMIT;
          case (in_data.mode)
            MODE_PUT: begin
              case (in_data.char_code)
                CHAR_NEWLINE: begin
                  col_next  = '0;
                  row_next  = row + 1'b1;
                  pos_next  = pos - AW'(col) + ROW_STRIDE;
                  line_feed = 1'b1;
                end
                CHAR_RETURN: begin
                  col_next = '0;
                  pos_next = pos - AW'(col);
                end
                CHAR_BACKSPACE: begin
                  // at column zero there is nothing to erase
                  if (col != '0) begin
                    col_next = col - 1'b1;
                    pos_next = pos - 1'b1;
                    wr_en    = 1'b1;
                    wr_addr  = pos - 1'b1;
                    wr_data  = blank_cell;
                  end
                end
                default: begin
                  wr_en    = 1'b1;
                  wr_addr  = pos;
                  wr_data  = {text_color, in_data.char_code};
                  pos_next = pos + 1'b1;
                  if (col == COL_LAST) begin
                    col_next  = '0;
                    row_next  = row + 1'b1;
                    line_feed = 1'b1;
                  end else begin
                    col_next = col + 1'b1;
                  end
                end
              endcase
              // past the last row: pin the cursor and start the scroll
              if (line_feed && row == ROW_LAST) begin
                row_next   = ROW_LAST;
                pos_next   = LAST_ROW_BASE;
                sweep_next = '0;
                state_next = ST_COPY;
              end
            end
            MODE_READ: begin
              if (in_range) begin
                rd_en         = 1'b1;
                rd_addr       = AW'(in_data.cell_index);
                read_hit_next = 1'b1;
              end
            end
            MODE_CLEAR: begin
              pos_next   = '0;
              row_next   = '0;
              col_next   = '0;
              sweep_next = '0;
              state_next = ST_BLANK;
            end
            default: begin
            end
          endcase
        end
      end

      // move every cell up one row: read one row ahead, write the cell behind
      ST_COPY: begin
        rd_en        = 1'b1;
        rd_addr      = sweep + ROW_STRIDE;
        wr_en        = wr_pend;
        wr_addr      = wr_addr_d;
        wr_data      = rd_data;
        wr_pend_next = 1'b1;
        sweep_next   = sweep + 1'b1;
        if (sweep == COPY_LAST) begin
          state_next = ST_DRAIN;
        end
      end

      // write the last copied cell, then blank the bottom row
      ST_DRAIN: begin
        wr_en      = 1'b1;
        wr_addr    = wr_addr_d;
        wr_data    = rd_data;
        sweep_next = COPY_COUNT;
        state_next = ST_BLANK;
      end

      ST_BLANK: begin
        wr_en      = 1'b1;
        wr_addr    = sweep;
        wr_data    = blank_cell;
        sweep_next = sweep + 1'b1;
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          state_next = ST_EMIT;
        end
      end

      // load the result once the output register is free
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      pos      <= '0;
      row      <= '0;
      col      <= '0;
      sweep    <= '0;
      wr_pend  <= 1'b0;
      read_hit <= 1'b0;
    end else begin
      state    <= state_next;
      pos      <= pos_next;
      row      <= row_next;
      col      <= col_next;
      sweep    <= sweep_next;
      wr_pend  <= wr_pend_next;
      read_hit <= read_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_d <= sweep;
  end

  // result register: hold the word until out_ready takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.cursor_pos <= POS_W'(pos);
      out_data.cell_value <= read_hit ? rd_data : '0;
    end
  end

endmodule

>>> hw/rtl/tccw_checker.sv
// tccw_checker: port-level assertions for the text console cell writer.
// Depends on tccw_pkg; bound to text_console_cell_writer at the end of this file.
module tccw_checker import tccw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // one word at a time: the input closes right after a word enters
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after a word was taken");

  // the reported cursor always lies on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(out_data.cursor_pos) < ROWS * COLUMNS)
    else $error("cursor position beyond the screen");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

endmodule

bind text_console_cell_writer tccw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tccw_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> bench/text_console_cell_writer_tb.sv
// text_console_cell_writer_tb: self-checking bench for the text console cell writer.
// Holds a scoreboard class with its own screen/cursor predictor, plus drive tasks.
// Depends on tccw_pkg and text_console_cell_writer; needs nothing else.
module text_console_cell_writer_tb import tccw_pkg::*; ();

  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  // random part: five color phases of equal length
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_WORDS  = 320;
  // hang guard: every word a full-screen pass with stalls, taken a few times over
  localparam int unsigned CYCLE_LIMIT  =
    (PHASES * PHASE_WORDS + 200) * (4 * CELLS + 64);

  // Scoreboard: mirrors the cell store, cursor and attribute, and keeps the
  // results owed by the block in acceptance order.
  class console_scoreboard;
    logic [CELL_W-1:0] screen [COLUMNS*ROWS];
    int unsigned       row;
    int unsigned       col;
    logic [CHAR_W-1:0] color;
    out_word_t         expected_words [$];
    int unsigned       error_count;
    int unsigned       result_count;

    function new();
      color        = RESET_COLOR;
      error_count  = 0;
      result_count = 0;
      clear_screen();
    endfunction

    function void clear_screen();
      for (int unsigned i = 0; i < COLUMNS * ROWS; i++) screen[i] = {color, CHAR_BLANK};
      row = 0;
      col = 0;
    endfunction

    function void load_color(logic [CHAR_W-1:0] c);
      color = c;
    endfunction

    function int unsigned cursor_linear();
      return row * COLUMNS + col;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void print_char(logic [CHAR_W-1:0] ch);
      case (ch)
        CHAR_NEWLINE: begin
          col = 0;
          row++;
        end
        CHAR_RETURN: col = 0;
        CHAR_BACKSPACE: begin
          if (col > 0) begin
            col--;
            screen[row*COLUMNS+col] = {color, CHAR_BLANK};
          end
        end
        default: begin
          screen[row*COLUMNS+col] = {color, ch};
          col++;
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
        end
      endcase
      if (row >= ROWS) begin
        for (int unsigned i = 0; i + COLUMNS < COLUMNS * ROWS; i++)
          screen[i] = screen[i+COLUMNS];
        for (int unsigned i = (ROWS - 1) * COLUMNS; i < COLUMNS * ROWS; i++)
          screen[i] = {color, CHAR_BLANK};
        row = ROWS - 1;
      end
    endfunction

    function void note_input(in_word_t w);
      out_word_t want;
      want.cell_value = '0;
      case (w.mode)
        MODE_PUT:   print_char(w.char_code);
        MODE_READ:  if (w.cell_index < COLUMNS * ROWS) want.cell_value = screen[w.cell_index];
        MODE_CLEAR: clear_screen();
        default: ;
      endcase
      want.cursor_pos = POS_W'(cursor_linear());
      expected_words.push_back(want);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("[%0t] mismatch on result %0d: %s got 0x%0h, want 0x%0h",
               $time, result_count, what, got, want);
      error_count++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("unrequested result, cursor_pos", got.cursor_pos, 0);
      end else begin
        want = expected_words.pop_front();
        if (got.cursor_pos !== want.cursor_pos)
          report_mismatch("cursor_pos", got.cursor_pos, want.cursor_pos);
        if (got.cell_value !== want.cell_value)
          report_mismatch("cell_value", got.cell_value, want.cell_value);
      end
      result_count++;
    endtask
  endclass

  // Every block input holds a known value from time zero.
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CHAR_W-1:0] cfg_data  = '0;

  bit                steady    = 1'b0;   // set: neither side idles
  int unsigned       cycle_count = 0;

  console_scoreboard sb;

  text_console_cell_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: drop ready in about a third of the cycles, unless steady.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 32);
  end

  // Monitor: sample all three channels on the rising edge. Check the result
  // before noting a new word; a result can never belong to a word taken at
  // the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (cfg_valid && cfg_ready) sb.load_color(cfg_data);
    end
  end

  // Hang guard.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_console_cell_writer regression: fail");
    $finish;
  end

  function automatic in_word_t make_word(mode_t m, logic [CHAR_W-1:0] ch,
                                         logic [INDEX_W-1:0] idx);
    in_word_t w;
    w.mode       = m;
    w.char_code  = ch;
    w.cell_index = idx;
    return w;
  endfunction

  // Mostly running text with control codes, reads close to the cursor and
  // anywhere, and a sprinkling of clears and unused-mode noise.
  function automatic in_word_t next_random_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned pos;
    w.mode       = MODE_PUT;
    w.char_code  = CHAR_W'($urandom_range(0, 255));
    w.cell_index = INDEX_W'($urandom_range(0, 2047));
    pick = $urandom_range(0, 999);
    if (pick < 3) begin
      w.mode = MODE_CLEAR;
    end else if (pick < 25) begin
      w.mode = mode_t'(MODE_UNUSED);
    end else if (pick < 175) begin
      w.mode = MODE_READ;
      if (pick < 100) begin
        // look back at what was just written
        pos = sb.cursor_linear();
        w.cell_index = INDEX_W'(pos - ($urandom_range(0, 3) % (pos + 1)));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       w.char_code = CHAR_NEWLINE;
      else if (pick < 11) w.char_code = CHAR_RETURN;
      else if (pick < 17) w.char_code = CHAR_BACKSPACE;
    end
    return w;
  endfunction

  // Present one word at the falling edge, with random gaps in front, and
  // hold it until the block takes it.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lower valid and hold off until every owed result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_color(input logic [CHAR_W-1:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CHAR_W-1:0] phase_color [PHASES];
    in_word_t          w;
    int unsigned       taken;

    sb = new();

    phase_color[0] = 8'hFF;
    phase_color[1] = 8'h00;
    phase_color[2] = CHAR_W'($urandom_range(0, 255));
    phase_color[3] = 8'h80;
    phase_color[4] = CHAR_W'($urandom_range(0, 255));

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset attribute; the first one waits out
    // the blanking pass behind in_ready.
    send_word(make_word(MODE_PUT,  8'h41, '0));
    send_word(make_word(MODE_PUT,  8'h00, '0));
    send_word(make_word(MODE_PUT,  8'hFF, '1));
    send_word(make_word(MODE_READ, '0, 11'd0));
    send_word(make_word(MODE_READ, '0, 11'd1));
    send_word(make_word(MODE_READ, '0, 11'd2));
    // backspace blanks the cell it steps back onto
    send_word(make_word(MODE_PUT,  CHAR_BACKSPACE, '0));
    send_word(make_word(MODE_READ, '0, 11'd2));
    send_word(make_word(MODE_PUT,  CHAR_RETURN, '0));
    // backspace at column zero leaves everything alone
    send_word(make_word(MODE_PUT,  CHAR_BACKSPACE, '0));
    send_word(make_word(MODE_READ, '0, 11'd0));
    send_word(make_word(MODE_PUT,  CHAR_NEWLINE, '0));
    send_word(make_word(MODE_PUT,  8'h7E, '0));
    send_word(make_word(MODE_READ, '0, 11'd80));
    send_word(make_word(MODE_READ, '0, INDEX_W'(CELLS - 1)));
    // reads past the last cell return zero
    send_word(make_word(MODE_READ, '0, INDEX_W'(CELLS)));
    send_word(make_word(MODE_READ, '1, '1));
    // unused mode changes nothing
    send_word(make_word(mode_t'(MODE_UNUSED), '1, '1));
    send_word(make_word(MODE_READ, '0, 11'd1));
    send_word(make_word(MODE_CLEAR, '1, '1));
    send_word(make_word(MODE_READ, '0, 11'd0));
    send_word(make_word(MODE_READ, '0, INDEX_W'(CELLS - 1)));
    wait_results_drained();

    // Random phases, each under its own attribute; the middle one runs
    // without any idling on either side.
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_color(phase_color[p]);
      steady = (p == 2);
      taken = 0;
      while (taken < PHASE_WORDS) begin
        w = next_random_word();
        send_word(w);
        if (w.mode != mode_t'(MODE_UNUSED)) taken++;
      end
      wait_results_drained();
    end
    steady = 1'b0;

    // Let any stray late result show up before the verdict.
    repeat (16) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("text_console_cell_writer regression: pass");
    end else begin
      $display("text_console_cell_writer regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_store.sv
hw/rtl/text_console_cell_writer.sv
hw/rtl/tccw_checker.sv
bench/text_console_cell_writer_tb.sv
